// ===== src/stbc_pkg.sv =====
package stbc_pkg;

    localparam int NUM_SPRITES = 8;
    localparam int IDX_W       = $clog2(NUM_SPRITES);

    localparam logic [7:0] BOX_X_OFFSET = 8'd24;
    localparam logic [7:0] BOX_X_SPAN   = 8'd48;
    localparam logic [7:0] BOX_Y_OFFSET = 8'd21;
    localparam logic [7:0] BOX_Y_SPAN   = 8'd42;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_DRAW  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] x_low;
        logic [7:0] y;
        logic [7:0] shape;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } table_wr_t;

endpackage

// ===== src/stbc_if.sv =====
interface stbc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] sprite_index;
    logic [8:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] shape;
    logic [7:0] collision_mask;

    modport source (
        output valid, kind, sprite_index, x_pos, y_pos, shape, collision_mask,
        input  ready
    );
    modport sink (
        input  valid, kind, sprite_index, x_pos, y_pos, shape, collision_mask,
        output ready
    );
endinterface

interface stbc_rsp_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [2:0] partner_index;
    logic [7:0] enable_mask;
    logic [7:0] high_x_mask;

    modport source (
        output valid, found, partner_index, enable_mask, high_x_mask,
        input  ready
    );
    modport sink (
        input  valid, found, partner_index, enable_mask, high_x_mask,
        output ready
    );
endinterface

// ===== src/sprite_table_box_collision.sv =====
// channel  dir  fields                                              handshake
// req      in   kind sprite_index x_pos y_pos shape collision_mask  valid/ready
// rsp      out  found partner_index enable_mask high_x_mask         valid/ready
//
// clear, draw and unused kinds go from idle straight to the finish state
// a query with its own bit set reads its own entry, then scans n = 1..8 entries,
// one table read per cycle on the single read port; other queries skip the scan
// one request at a time; a new request is taken while a response waits
// reset clears the masks and marks all table entries as zero at once
module sprite_table_box_collision (
    input  logic       clk,
    input  logic       rst_n,
    stbc_req_if.sink   req,
    stbc_rsp_if.source rsp
);

    localparam int IW = stbc_pkg::IDX_W;
    localparam int NS = stbc_pkg::NUM_SPRITES;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_OWN    = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [NS-1:0]     enable_reg, enable_next;
    logic [NS-1:0]     xhigh_reg, xhigh_next;
    logic [NS-1:0]     others_reg, others_next;
    logic [IW-1:0]     scan_reg, scan_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     partner_reg, partner_next;
    stbc_pkg::entry_t  own_reg, own_next;

    logic              out_valid_reg;
    logic              out_found_reg;
    logic [IW-1:0]     out_partner_reg;
    logic [NS-1:0]     out_enable_reg;
    logic [NS-1:0]     out_xhigh_reg;

    logic                accept;
    logic                out_free;
    logic                tbl_clear;
    stbc_pkg::table_wr_t tbl_wr;
    logic [IW-1:0]       rd_addr;
    stbc_pkg::entry_t    rd_data;
    logic                hit;
    logic [NS-1:0]       req_bit;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;
    assign req_bit  = NS'(1) << req.sprite_index;

    assign tbl_clear    = accept && (req.kind == stbc_pkg::KIND_CLEAR);
    assign tbl_wr.en    = accept && (req.kind == stbc_pkg::KIND_DRAW);
    assign tbl_wr.addr  = req.sprite_index;
    assign tbl_wr.data  = '{x_low: req.x_pos[7:0], y: req.y_pos, shape: req.shape};

    stbc_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (tbl_clear),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stbc_box u_box (
        .own   (own_reg),
        .other (rd_data),
        .hit   (hit)
    );

    always_comb
    begin
        state_next   = state_reg;
        enable_next  = enable_reg;
        xhigh_next   = xhigh_reg;
        others_next  = others_reg;
        scan_next    = scan_reg;
        found_next   = found_reg;
        partner_next = partner_reg;
        own_next     = own_reg;
        rd_addr      = req.sprite_index;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    found_next   = 1'b0;
                    partner_next = '0;
                    state_next   = ST_FINISH;
                    unique case (stbc_pkg::kind_t'(req.kind))
                        stbc_pkg::KIND_CLEAR:
                        begin
                            enable_next = '0;
                            xhigh_next  = '0;
                        end
                        stbc_pkg::KIND_DRAW:
                        begin
                            enable_next = enable_reg | req_bit;
                            if (req.x_pos[8])
                            begin
                                xhigh_next = xhigh_reg | req_bit;
                            end
                            else
                            begin
                                xhigh_next = xhigh_reg & ~req_bit;
                            end
                        end
                        stbc_pkg::KIND_QUERY:
                        begin
                            // own entry is being read this cycle
                            if ((req.collision_mask & req_bit) != '0)
                            begin
                                others_next = req.collision_mask & ~req_bit;
                                state_next  = ST_OWN;
                            end
                        end
                        stbc_pkg::KIND_NONE:
                        begin
                        end
                    endcase
                end
            end
            ST_OWN:
            begin
                own_next   = rd_data;
                rd_addr    = '0;
                scan_next  = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                rd_addr = scan_reg + IW'(1);
                if (others_reg[scan_reg] && hit)
                begin
                    found_next   = 1'b1;
                    partner_next = scan_reg;
                    state_next   = ST_FINISH;
                end
                else if (scan_reg == IW'(NS - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    scan_next = scan_reg + IW'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            enable_reg <= '0;
            xhigh_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            enable_reg <= enable_next;
            xhigh_reg  <= xhigh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        others_reg  <= others_next;
        scan_reg    <= scan_next;
        found_reg   <= found_next;
        partner_reg <= partner_next;
        own_reg     <= own_next;
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FINISH) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_found_reg   <= found_reg;
            out_partner_reg <= partner_reg;
            out_enable_reg  <= enable_reg;
            out_xhigh_reg   <= xhigh_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = out_found_reg;
    assign rsp.partner_index = out_partner_reg;
    assign rsp.enable_mask   = out_enable_reg;
    assign rsp.high_x_mask   = out_xhigh_reg;

    a_draw_enables: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.kind == stbc_pkg::KIND_DRAW)
        |=> enable_reg[$past(req.sprite_index)])
        else $error("draw did not set the enable bit");

    a_clear_masks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.kind == stbc_pkg::KIND_CLEAR)
        |=> (enable_reg == '0) && (xhigh_reg == '0))
        else $error("clear left mask bits set");

    a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN)
        |-> ($past(state_reg) == ST_OWN) || ($past(state_reg) == ST_SCAN))
        else $error("scan started without reading own entry");

    a_found_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && found_reg |-> others_reg[partner_reg])
        else $error("partner not flagged in collision mask");

endmodule

// ===== src/stbc_table.sv =====
module stbc_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  stbc_pkg::table_wr_t        wr,
    input  logic [stbc_pkg::IDX_W-1:0] rd_addr,
    output stbc_pkg::entry_t           rd_data
);

    stbc_pkg::entry_t                    mem [stbc_pkg::NUM_SPRITES];
    logic [stbc_pkg::NUM_SPRITES-1:0]    valid_reg;
    stbc_pkg::entry_t                    rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // entries never written since reset or clear read as zero
    always_ff @(posedge clk)
    begin
        if (valid_reg[rd_addr])
        begin
            rd_data_reg <= mem[rd_addr];
        end
        else
        begin
            rd_data_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/stbc_box.sv =====
module stbc_box (
    input  stbc_pkg::entry_t own,
    input  stbc_pkg::entry_t other,
    output logic             hit
);

    logic [7:0] dx;
    logic [7:0] dy;

    // differences wrap at 8 bits
    assign dx  = own.x_low - other.x_low + stbc_pkg::BOX_X_OFFSET;
    assign dy  = own.y - other.y + stbc_pkg::BOX_Y_OFFSET;
    assign hit = (dx < stbc_pkg::BOX_X_SPAN) && (dy < stbc_pkg::BOX_Y_SPAN);

endmodule

// ===== bench/sprite_collision_checker.sv =====
module sprite_collision_checker (
    input  logic clk,
    input  logic rst_n,
    stbc_req_if  req,
    stbc_rsp_if  rsp,
    output int   mismatches,
    output int   awaiting,
    output int   partner_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    import stbc_pkg::*;

    typedef struct packed {
        logic       found;
        logic [2:0] partner;
        logic [7:0] enables;
        logic [7:0] high_x;
    } sprite_rsp_t;

    logic [7:0]  x_low_tbl [NUM_SPRITES];
    logic [7:0]  y_tbl     [NUM_SPRITES];
    logic [7:0]  shape_tbl [NUM_SPRITES];
    logic [7:0]  enables;
    logic [7:0]  high_x;
    sprite_rsp_t rsp_expect_q [$];
    int          bad_count;
    int          hit_count;

    task automatic clear_table();
        for (int i = 0; i < NUM_SPRITES; i++)
        begin
            x_low_tbl[i] = '0;
            y_tbl[i]     = '0;
            shape_tbl[i] = '0;
        end
        enables = '0;
        high_x  = '0;
    endtask

    // differences wrap at 8 bits, the ninth x bit is not part of the test
    function automatic logic boxes_touch(int a, int b);
        logic [7:0] dx;
        logic [7:0] dy;
        dx = x_low_tbl[a] - x_low_tbl[b] + BOX_X_OFFSET;
        dy = y_tbl[a] - y_tbl[b] + BOX_Y_OFFSET;
        return (dx < BOX_X_SPAN) && (dy < BOX_Y_SPAN);
    endfunction

    task automatic predict_request();
        sprite_rsp_t exp_rsp;
        logic [7:0]  others;
        int          idx;
        int          j;
        exp_rsp = '0;
        idx     = int'(req.sprite_index);
        case (kind_t'(req.kind))
            KIND_CLEAR:
                clear_table();
            KIND_DRAW:
            begin
                enables[idx]   = 1'b1;
                high_x[idx]    = req.x_pos[8];
                x_low_tbl[idx] = req.x_pos[7:0];
                y_tbl[idx]     = req.y_pos;
                shape_tbl[idx] = req.shape;
            end
            KIND_QUERY:
            begin
                // only a sprite flagged itself looks for a partner
                if (req.collision_mask[idx])
                begin
                    others      = req.collision_mask;
                    others[idx] = 1'b0;
                    for (j = 0; j < NUM_SPRITES; j++)
                    begin
                        if (!exp_rsp.found && others[j] && boxes_touch(idx, j))
                        begin
                            exp_rsp.found   = 1'b1;
                            exp_rsp.partner = 3'(j);
                        end
                    end
                end
            end
            KIND_NONE: ;
            default: ;
        endcase
        exp_rsp.enables = enables;
        exp_rsp.high_x  = high_x;
        rsp_expect_q.push_back(exp_rsp);
    endtask

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            bad_count++;
        end
    endtask

    task automatic check_response();
        sprite_rsp_t exp_rsp;
        if (rsp_expect_q.size() == 0)
        begin
            $display("%0t: response with no request pending, expected none, got %0b/%0d/%02h/%02h",
                     $time, rsp.found, rsp.partner_index, rsp.enable_mask, rsp.high_x_mask);
            bad_count++;
        end
        else
        begin
            exp_rsp = rsp_expect_q.pop_front();
            if (exp_rsp.found)
                hit_count++;
            compare_field("found", 8'(exp_rsp.found), 8'(rsp.found));
            compare_field("partner_index", 8'(exp_rsp.partner), 8'(rsp.partner_index));
            compare_field("enable_mask", exp_rsp.enables, rsp.enable_mask);
            compare_field("high_x_mask", exp_rsp.high_x, rsp.high_x_mask);
        end
    endtask

    // a response leaving at the same edge belongs to an older request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_table();
            rsp_expect_q.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                check_response();
            if (req.valid && req.ready)
                predict_request();
        end
        mismatches   <= bad_count;
        awaiting     <= rsp_expect_q.size();
        partner_hits <= hit_count;
    end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stbc_pkg::*;

    localparam int STALL_LIMIT      = 5000;
    localparam int RANDOM_PER_PHASE = 330;
    localparam int DRAIN_CYCLES     = 16;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] idx;
        logic [8:0] x;
        logic [7:0] y;
        logic [7:0] shape;
        logic [7:0] coll;
    } sprite_req_t;

    logic       clk = 1'b0;
    logic       rst_n;
    int         snd_idle;
    int         rcv_idle;
    int         stall_cycles;
    int         sent_by_kind [4];
    int         mismatches;
    int         awaiting;
    int         partner_hits;
    logic [7:0] cluster_x;
    logic [7:0] cluster_y;

    stbc_req_if req_ch ();
    stbc_rsp_if rsp_ch ();

    sprite_table_box_collision dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sprite_collision_checker collision_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .mismatches   (mismatches),
        .awaiting     (awaiting),
        .partner_hits (partner_hits)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic sprite_req_t mk(kind_t k, int idx, int x, int y, int shp, int coll);
        sprite_req_t it;
        it.kind  = k;
        it.idx   = 3'(idx);
        it.x     = 9'(x);
        it.y     = 8'(y);
        it.shape = 8'(shp);
        it.coll  = 8'(coll);
        return it;
    endfunction

    function automatic sprite_req_t random_req();
        sprite_req_t it;
        int unsigned pick;
        pick     = $urandom_range(99);
        it.idx   = 3'($urandom_range(7));
        it.x     = 9'($urandom);
        it.y     = 8'($urandom);
        it.shape = 8'($urandom);
        it.coll  = 8'($urandom);
        if (pick < 3)
            it.kind = KIND_CLEAR;
        else if (pick < 7)
            it.kind = KIND_NONE;
        else if (pick < 50)
            it.kind = KIND_DRAW;
        else
            it.kind = KIND_QUERY;
        // most draws land around one spot so that queries find partners
        if (it.kind == KIND_DRAW && $urandom_range(3) != 0)
        begin
            it.x[7:0] = cluster_x + 8'($urandom_range(64)) - 8'd32;
            it.y      = cluster_y + 8'($urandom_range(56)) - 8'd28;
        end
        if (it.kind == KIND_QUERY && $urandom_range(4) != 0)
            it.coll[it.idx] = 1'b1;
        return it;
    endfunction

    task automatic send_req(sprite_req_t it);
        while ($urandom_range(99) < snd_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.kind           <= it.kind;
        req_ch.sprite_index   <= it.idx;
        req_ch.x_pos          <= it.x;
        req_ch.y_pos          <= it.y;
        req_ch.shape          <= it.shape;
        req_ch.collision_mask <= it.coll;
        sent_by_kind[int'(it.kind)]++;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    // hold off new requests until every response is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (awaiting == 0);
        @(posedge clk);
    endtask

    initial
    begin
        int snd_pct [3];
        int rcv_pct [3];
        snd_pct = '{24, 61, 0};
        rcv_pct = '{61, 24, 0};
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.kind           = KIND_CLEAR;
        req_ch.sprite_index   = '0;
        req_ch.x_pos          = '0;
        req_ch.y_pos          = '0;
        req_ch.shape          = '0;
        req_ch.collision_mask = '0;
        snd_idle              = snd_pct[0];
        rcv_idle              = rcv_pct[0];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty table: every entry sits at 0,0 and overlaps every other
        send_req(mk(KIND_QUERY, 3, 0, 0, 0, 8'hff));
        send_req(mk(KIND_DRAW, 0, 9'h1ff, 8'hff, 8'hff, 0));
        // inside by one on both axes
        send_req(mk(KIND_DRAW, 1, 9'h0e8, 8'heb, 8'h00, 8'hff));
        // x just outside
        send_req(mk(KIND_DRAW, 2, 9'h1e7, 8'hff, 8'haa, 0));
        // y just outside
        send_req(mk(KIND_DRAW, 3, 9'h0ff, 8'hea, 8'h55, 0));
        send_req(mk(KIND_QUERY, 0, 9'h1ff, 0, 0, 8'hff));
        send_req(mk(KIND_QUERY, 0, 0, 8'hff, 8'hff, 8'hfd));
        send_req(mk(KIND_QUERY, 1, 0, 0, 0, 8'h01));
        send_req(mk(KIND_QUERY, 1, 0, 0, 0, 8'h03));
        send_req(mk(KIND_QUERY, 2, 0, 0, 0, 8'h05));
        send_req(mk(KIND_QUERY, 5, 0, 0, 0, 8'h20));
        send_req(mk(KIND_QUERY, 2, 0, 0, 0, 8'h00));
        send_req(mk(KIND_NONE, 7, 9'h1ff, 8'hff, 8'hff, 8'hff));
        send_req(mk(KIND_DRAW, 0, 9'h0ff, 8'h00, 8'h0f, 0));
        send_req(mk(KIND_DRAW, 7, 9'h100, 8'h80, 8'hf0, 0));
        send_req(mk(KIND_QUERY, 7, 0, 0, 0, 8'hff));
        send_req(mk(KIND_QUERY, 7, 0, 0, 0, 8'h80));
        // disabled sprite queried, its never-written entry reads as zero but still counts
        send_req(mk(KIND_QUERY, 6, 0, 0, 0, 8'hc0));
        send_req(mk(KIND_CLEAR, 4, 9'h1ff, 8'hff, 8'hff, 8'hff));
        send_req(mk(KIND_QUERY, 7, 0, 0, 0, 8'hff));
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            snd_idle  = snd_pct[phase];
            rcv_idle  = rcv_pct[phase];
            cluster_x = 8'($urandom);
            cluster_y = 8'($urandom);
            repeat (RANDOM_PER_PHASE)
                send_req(random_req());
            wait_drained();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d clears, %0d draws, %0d queries, %0d unused-kind requests",
                 sent_by_kind[KIND_CLEAR], sent_by_kind[KIND_DRAW],
                 sent_by_kind[KIND_QUERY], sent_by_kind[KIND_NONE]);
        $display("%0d queries found a partner; idling sender/receiver 24/61, 61/24, none",
                 partner_hits);
        if (mismatches == 0 && awaiting == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("%0d mismatches, %0d responses never arrived", mismatches, awaiting);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/stbc_pkg.sv
src/stbc_if.sv
src/stbc_table.sv
src/stbc_box.sv
src/sprite_table_box_collision.sv
bench/sprite_collision_checker.sv
bench/tb_top.sv
